// File: src/qmp_pkg.sv
// ----------------------------------------------------------------------------
// qmp_pkg
// Shared constants, codes and types of the quadratic motion solver.
// ----------------------------------------------------------------------------
package qmp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = 5;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_INDEX = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BEFORE  = 2'd1;
  localparam logic [1:0] ST_NOSOL   = 2'd2;
  localparam logic [1:0] ST_NEGTIME = 2'd3;

  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_SPEED  = 3'd1;
  localparam logic [2:0] REG_HALFAC = 3'd2;
  localparam logic [2:0] REG_RATE   = 3'd3;
  localparam logic [2:0] REG_TOL    = 3'd4;

  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic [19:0]        rate;
    logic [15:0]        tol;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos;
    logic [1:0]         st;
    logic               lin;
    logic [31:0]        d;
    logic [63:0]        qq;
  } front_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos;
    logic [1:0]         st;
    logic               lin;
    logic [31:0]        d;
    logic [31:0]        root;
  } root_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? ($unsigned(~x) + 32'd1) : $unsigned(x);
  endfunction

endpackage

// File: src/qmp_if.sv
// ----------------------------------------------------------------------------
// qmp_if
// Valid/ready channels for query beats and result beats.
// ----------------------------------------------------------------------------
interface qmp_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] query_value;

  modport source (output valid, operation, query_value, input ready);
  modport sink (input valid, operation, query_value, output ready);
endinterface

interface qmp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic [31:0]        sample_index;
  logic [1:0]         status;

  modport source (output valid, position, sample_index, status, input ready);
  modport sink (input valid, position, sample_index, status, output ready);
endinterface

// File: src/qmp_front.sv
// ----------------------------------------------------------------------------
// qmp_front
// Four stages: polynomial evaluation and the discriminant of the inverse.
// ----------------------------------------------------------------------------
module qmp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic               in_op,
  input  logic signed [31:0] in_q,
  input  qmp_pkg::cfg_t      cfg,
  output logic               out_valid,
  output qmp_pkg::front_t    out_item
);

  localparam int F  = qmp_pkg::FRAC_BITS;
  localparam int IW = 64 - F + 1;
  localparam int HW = IW - F + 32;
  localparam int LW = F + 33;
  localparam int SW = HW + 1;

  logic [31:0] c1_mag, c2_mag;
  logic        c2_neg, c1_zero, lin;

  assign c1_mag  = qmp_pkg::mag32(cfg.c1);
  assign c2_mag  = qmp_pkg::mag32(cfg.c2);
  assign c2_neg  = cfg.c2[31];
  assign c1_zero = (cfg.c1 == 32'sd0);
  assign lin     = (c2_mag < {16'd0, cfg.tol}) || (cfg.c2 == 32'sd0);

  // stage 1
  logic               v1_r, op1_r, bef1_r;
  logic signed [31:0] q1_r;
  logic signed [63:0] p1_r, p1_nxt;
  logic signed [32:0] d1_r, d1_nxt;

  assign p1_nxt = 64'(cfg.c2) * 64'(in_q);
  assign d1_nxt = 33'(in_q) - 33'(cfg.c0);

  // stage 2
  logic                 v2_r, op2_r, bef2_r;
  logic signed [31:0]   q2_r;
  logic signed [IW-1:0] inner2_r, inner2_nxt, p1_sh;
  logic [31:0]          d2_r;
  logic [63:0]          a2_r, b2_r, a2_nxt, b2_nxt;

  assign p1_sh      = IW'(p1_r >>> F);
  assign inner2_nxt = p1_sh + IW'(cfg.c1);
  assign a2_nxt     = (64'(c1_mag) * 64'(c1_mag)) >> 2;
  assign b2_nxt     = 64'(c2_mag) * 64'(d1_r[31:0]);

  // stage 3
  logic                 v3_r, op3_r;
  logic signed [HW-1:0] hq3_r, hq3_nxt;
  logic signed [LW-1:0] lq3_r, lq3_nxt;
  logic [63:0]          qq3_r, qq3_nxt;
  logic [1:0]           st3_r, st3_nxt;
  logic [31:0]          d3_r;
  logic                 neg_disc;

  assign hq3_nxt  = $signed(inner2_r[IW-1:F]) * HW'(q2_r);
  assign lq3_nxt  = $signed({1'b0, inner2_r[F-1:0]}) * LW'(q2_r);
  assign qq3_nxt  = c2_neg ? (a2_r - b2_r) : (a2_r + b2_r);
  assign neg_disc = c2_neg && (b2_r > a2_r);

  always_comb begin
    st3_nxt = qmp_pkg::ST_OK;
    if (op2_r == qmp_pkg::OP_INDEX) begin
      priority if (bef2_r) begin
        st3_nxt = qmp_pkg::ST_BEFORE;
      end else if (c1_zero) begin
        st3_nxt = qmp_pkg::ST_NOSOL;
      end else if (!lin && neg_disc) begin
        st3_nxt = qmp_pkg::ST_NOSOL;
      end else begin
        st3_nxt = qmp_pkg::ST_OK;
      end
    end
  end

  // stage 4: floor(inner*q / 2^F) is split as hi*q + floor(lo*q / 2^F).
  logic signed [SW-1:0] sum4;
  logic                 ovf4;
  logic signed [31:0]   pos4_nxt;
  logic                 v4_r;
  qmp_pkg::front_t      item4_r;

  assign sum4 = SW'(hq3_r) + SW'(lq3_r >>> F) + SW'(cfg.c0);
  assign ovf4 = !((&sum4[SW-1:31]) || (~|sum4[SW-1:31]));

  always_comb begin
    if (op3_r != qmp_pkg::OP_EVAL) begin
      pos4_nxt = 32'sd0;
    end else if (ovf4) begin
      pos4_nxt = sum4[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      pos4_nxt = sum4[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r       <= in_op;
      q1_r        <= in_q;
      p1_r        <= p1_nxt;
      d1_r        <= d1_nxt;
      bef1_r      <= (cfg.c0 > in_q);
      op2_r       <= op1_r;
      q2_r        <= q1_r;
      inner2_r    <= inner2_nxt;
      d2_r        <= d1_r[31:0];
      bef2_r      <= bef1_r;
      a2_r        <= a2_nxt;
      b2_r        <= b2_nxt;
      op3_r       <= op2_r;
      hq3_r       <= hq3_nxt;
      lq3_r       <= lq3_nxt;
      qq3_r       <= qq3_nxt;
      st3_r       <= st3_nxt;
      d3_r        <= d2_r;
      item4_r.op  <= op3_r;
      item4_r.pos <= pos4_nxt;
      item4_r.st  <= st3_r;
      item4_r.lin <= lin;
      item4_r.d   <= d3_r;
      item4_r.qq  <= qq3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item4_r;

endmodule

// File: src/qmp_sqrt.sv
// ----------------------------------------------------------------------------
// qmp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qmp_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  qmp_pkg::front_t in_item,
  output logic            out_valid,
  output qmp_pkg::root_t  out_item
);

  localparam int N = qmp_pkg::SQ_STEPS;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos;
    logic [1:0]         st;
    logic               lin;
    logic [31:0]        d;
    logic [63:0]        rad;
    logic [33:0]        rem;
    logic [31:0]        root;
  } sq_t;

  logic [N-1:0] v_r;
  sq_t          stg_r [N];
  sq_t          stg_nxt [N];
  sq_t          src [N];

  always_comb begin
    src[0].op   = in_item.op;
    src[0].pos  = in_item.pos;
    src[0].st   = in_item.st;
    src[0].lin  = in_item.lin;
    src[0].d    = in_item.d;
    src[0].rad  = in_item.qq;
    src[0].rem  = '0;
    src[0].root = '0;
    for (int k = 1; k < N; k++) begin
      src[k] = stg_r[k-1];
    end
  end

  // Bring down two radicand bits, try (4*root + 1) against the remainder.
  always_comb begin
    logic [35:0] acc;
    logic [35:0] trial;
    for (int k = 0; k < N; k++) begin
      acc            = {src[k].rem, src[k].rad[63:62]};
      trial          = {2'b00, src[k].root, 2'b01};
      stg_nxt[k]     = src[k];
      stg_nxt[k].rad = {src[k].rad[61:0], 2'b00};
      if (acc >= trial) begin
        stg_nxt[k].rem  = 34'(acc - trial);
        stg_nxt[k].root = {src[k].root[30:0], 1'b1};
      end else begin
        stg_nxt[k].rem  = acc[33:0];
        stg_nxt[k].root = {src[k].root[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid     = v_r[N-1];
  assign out_item.op   = stg_r[N-1].op;
  assign out_item.pos  = stg_r[N-1].pos;
  assign out_item.st   = stg_r[N-1].st;
  assign out_item.lin  = stg_r[N-1].lin;
  assign out_item.d    = stg_r[N-1].d;
  assign out_item.root = stg_r[N-1].root;

endmodule

// File: src/qmp_div.sv
// ----------------------------------------------------------------------------
// qmp_div
// Root to time numerator, rate scaling and a pipelined saturating divider.
// ----------------------------------------------------------------------------
module qmp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  qmp_pkg::root_t     in_item,
  input  qmp_pkg::cfg_t      cfg,
  output logic               out_valid,
  output logic signed [31:0] out_pos,
  output logic [31:0]        out_idx,
  output logic [1:0]         out_st
);

  localparam int N = qmp_pkg::DIV_STEPS;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos;
    logic [1:0]         st;
    logic               sat;
    logic [32:0]        den;
    logic [32:0]        rem;
    logic [31:0]        qn;
  } dv_t;

  // stage 1: signed numerator and denominator, sign test
  logic signed [35:0] two_s, num;
  logic               den_neg, neg_q;
  logic [32:0]        dmag_nxt;
  logic [1:0]         st1_nxt;
  logic [35:0]        nabs;

  assign two_s    = 36'({in_item.root, 1'b0});
  assign den_neg  = in_item.lin ? cfg.c1[31] : cfg.c2[31];
  assign dmag_nxt = in_item.lin ? {1'b0, qmp_pkg::mag32(cfg.c1)}
                                : {qmp_pkg::mag32(cfg.c2), 1'b0};

  always_comb begin
    if (in_item.lin) begin
      num = 36'({1'b0, in_item.d});
    end else if (cfg.c1 > 32'sd0) begin
      num = two_s - 36'(cfg.c1);
    end else begin
      num = -two_s - 36'(cfg.c1);
    end
  end

  assign neg_q = (num != 36'sd0) && (num[35] != den_neg);
  assign nabs  = num[35] ? $unsigned(-num) : $unsigned(num);

  always_comb begin
    if (in_item.st != qmp_pkg::ST_OK) begin
      st1_nxt = in_item.st;
    end else if ((in_item.op == qmp_pkg::OP_INDEX) && neg_q) begin
      st1_nxt = qmp_pkg::ST_NEGTIME;
    end else begin
      st1_nxt = qmp_pkg::ST_OK;
    end
  end

  logic               v1_r, op1_r;
  logic signed [31:0] pos1_r;
  logic [1:0]         st1_r;
  logic [33:0]        nmag1_r;
  logic [32:0]        dmag1_r;

  // stage 2: scale by the sample rate
  logic               v2_r, op2_r;
  logic signed [31:0] pos2_r;
  logic [1:0]         st2_r;
  logic [53:0]        prod2_r;
  logic [32:0]        dmag2_r;

  // Quotients of 2^32 and above saturate, so only 32 bits are developed.
  logic [N-1:0] v_r;
  dv_t          stg_r [N];
  dv_t          stg_nxt [N];
  dv_t          src [N];
  logic         sat_in;

  assign sat_in = ({11'd0, prod2_r[53:32]} >= dmag2_r);

  always_comb begin
    src[0].op  = op2_r;
    src[0].pos = pos2_r;
    src[0].st  = st2_r;
    src[0].sat = sat_in;
    src[0].den = dmag2_r;
    src[0].rem = sat_in ? 33'd0 : {11'd0, prod2_r[53:32]};
    src[0].qn  = prod2_r[31:0];
    for (int k = 1; k < N; k++) begin
      src[k] = stg_r[k-1];
    end
  end

  always_comb begin
    logic [33:0] acc;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      acc           = {src[k].rem, src[k].qn[31]};
      ge            = (acc >= {1'b0, src[k].den});
      stg_nxt[k]    = src[k];
      stg_nxt[k].rem = ge ? 33'(acc - {1'b0, src[k].den}) : acc[32:0];
      stg_nxt[k].qn  = {src[k].qn[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v_r  <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v_r  <= {v_r[N-2:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_item.op;
      pos1_r  <= in_item.pos;
      st1_r   <= st1_nxt;
      nmag1_r <= nabs[33:0];
      dmag1_r <= dmag_nxt;
      op2_r   <= op1_r;
      pos2_r  <= pos1_r;
      st2_r   <= st1_r;
      prod2_r <= 54'(cfg.rate) * 54'(nmag1_r);
      dmag2_r <= dmag1_r;
      for (int k = 0; k < N; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_pos   = stg_r[N-1].pos;
  assign out_st    = stg_r[N-1].st;
  assign out_idx   = ((stg_r[N-1].op == qmp_pkg::OP_INDEX) &&
                      (stg_r[N-1].st == qmp_pkg::ST_OK))
                     ? (stg_r[N-1].sat ? 32'hffff_ffff : stg_r[N-1].qn) : 32'd0;

endmodule

// File: src/quadratic_motion_position_time_solver_unit.sv
// ----------------------------------------------------------------------------
// quadratic_motion_position_time_solver_unit
// Position from time, or sample index from position, for c0 + c1*t + c2*t^2.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_bus    sink       operation, query_value
//  out_bus   source     position, sample_index, status
//  APB       slave      coefficient, rate and tolerance registers
//
// One beat enters per cycle while out_bus is not stalled; every beat
// passes through 4 front stages, 32 root stages, 2 scaling stages,
// 32 divider stages and the output register. Reset is synchronous and
// clears all valid bits and restores the register defaults. While a result
// beat waits on out_bus the whole pipeline holds; nothing is lost.
// ----------------------------------------------------------------------------
module quadratic_motion_position_time_solver_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  qmp_in_if.sink                       in_bus,
  qmp_out_if.source                    out_bus,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qmp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  qmp_pkg::cfg_t cfg_r;
  logic [2:0]    reg_sel;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c0   <= 32'sd0;
      cfg_r.c1   <= 32'sd65536;
      cfg_r.c2   <= 32'sd0;
      cfg_r.rate <= 20'd2000;
      cfg_r.tol  <= 16'd7;
    end else if (wr_en) begin
      unique case (reg_sel)
        qmp_pkg::REG_OFFSET: cfg_r.c0   <= pwdata;
        qmp_pkg::REG_SPEED:  cfg_r.c1   <= pwdata;
        qmp_pkg::REG_HALFAC: cfg_r.c2   <= pwdata;
        qmp_pkg::REG_RATE:   cfg_r.rate <= pwdata[19:0];
        qmp_pkg::REG_TOL:    cfg_r.tol  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      qmp_pkg::REG_OFFSET: prdata = cfg_r.c0;
      qmp_pkg::REG_SPEED:  prdata = cfg_r.c1;
      qmp_pkg::REG_HALFAC: prdata = cfg_r.c2;
      qmp_pkg::REG_RATE:   prdata = {12'd0, cfg_r.rate};
      qmp_pkg::REG_TOL:    prdata = {16'd0, cfg_r.tol};
      default:             prdata = 32'd0;
    endcase
  end

  logic en;
  logic out_v_r;

  assign en           = !out_v_r || out_bus.ready;
  assign in_bus.ready = en;

  logic               f_valid, s_valid, d_valid;
  qmp_pkg::front_t    f_item;
  qmp_pkg::root_t     s_item;
  logic signed [31:0] d_pos;
  logic [31:0]        d_idx;
  logic [1:0]         d_st;

  qmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_bus.valid),
    .in_op     (in_bus.operation),
    .in_q      (in_bus.query_value),
    .cfg       (cfg_r),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  qmp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .out_valid (s_valid),
    .out_item  (s_item)
  );

  qmp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_item   (s_item),
    .cfg       (cfg_r),
    .out_valid (d_valid),
    .out_pos   (d_pos),
    .out_idx   (d_idx),
    .out_st    (d_st)
  );

  logic signed [31:0] pos_r;
  logic [31:0]        idx_r;
  logic [1:0]         st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= d_pos;
      idx_r <= d_idx;
      st_r  <= d_st;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.position     = pos_r;
  assign out_bus.sample_index = idx_r;
  assign out_bus.status       = st_r;

  // Any status other than ok carries a zero index.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (st_r != qmp_pkg::ST_OK)) |-> (idx_r == 32'd0))
    else $error("nonzero sample index with error status");

  // A nonzero position only comes from an evaluation, which is always ok.
  a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (pos_r != 32'sd0)) |-> (st_r == qmp_pkg::ST_OK))
    else $error("position reported with error status");

  // Reset leaves no result beat pending.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_v_r)
    else $error("result valid right after reset");

endmodule
